### src/sfm_pkg.sv
package sfm_pkg;

    // Default sizing of the search engine
    localparam int MAX_NEEDLE_DEF     = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    // Fixed field widths of the channels
    localparam int LEN_W     = 6;
    localparam int NIDX_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int POS_OUT_W = 16;

    // Item modes
    localparam logic MODE_NEEDLE = 1'b0;
    localparam logic MODE_TEXT   = 1'b1;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] position;
    } result_t;

endpackage

### src/sfm_if.sv
interface sfm_item_if;
    import sfm_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [NIDX_W-1:0] needle_index;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_text;

    modport source (output valid, mode, needle_index, data_byte, last_of_text, input ready);
    modport sink   (input valid, mode, needle_index, data_byte, last_of_text, output ready);
endinterface

interface sfm_result_if;
    import sfm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [POS_OUT_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

interface sfm_cfg_if;
    import sfm_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] needle_length;

    modport source (output valid, needle_length, input ready);
    modport sink   (input valid, needle_length, output ready);
endinterface

### src/substring_first_match_top.sv
// A result is registered in the output register, or in the skid entry if full.
// Throughput: one item per cycle while the skid entry is empty; the
// partial-match vector updates in one step.
// A two-entry output stage (result register plus skid) keeps input flowing.
// Reset (rst_n, asynchronous, active low) clears the search state, the output
// stage and sets needle_length to 1; the needle store is not cleared.
module substring_first_match_top #(
    parameter int MAX_NEEDLE     = sfm_pkg::MAX_NEEDLE_DEF,
    parameter int POSITION_WIDTH = sfm_pkg::POSITION_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfm_item_if.sink    item,
    sfm_result_if.source result,
    sfm_cfg_if.sink     cfg
);
    import sfm_pkg::*;

    localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int LEFF_W = 9;

    // Needle store and search state
    logic [BYTE_W-1:0]         needle_reg [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0]     pmv_reg;
    logic [MAX_NEEDLE-1:0]     pmv_next;
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic [POSITION_WIDTH-1:0] pos_next;
    logic                      reported_reg;
    logic                      reported_next;
    logic [LEN_W-1:0]          len_reg;

    // Output stage
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    logic                      item_fire;
    logic                      text_fire;
    logic                      out_fire;
    logic [LEFF_W-1:0]         len_eff;
    logic [LEFF_W-1:0]         len_m1;
    logic [MAX_NEEDLE-1:0]     cmp_vec;
    logic [MAX_NEEDLE-1:0]     pmv_shift;
    logic                      hit;
    logic [POSITION_WIDTH-1:0] len_m1_ext;
    logic [POSITION_WIDTH-1:0] start_pos;
    logic [POSITION_WIDTH+POS_OUT_W-1:0] start_wide;
    result_t                   res;
    logic                      res_valid;

    assign item_fire  = item.valid && item.ready;
    assign text_fire  = item_fire && (item.mode == MODE_TEXT);
    assign out_fire   = result.valid && result.ready;
    assign item.ready = !skid_valid_reg;
    assign cfg.ready  = 1'b1;

    // Clamp the needle length to 1..MAX_NEEDLE
    always_comb
    begin
        len_eff = LEFF_W'(len_reg);
        if (len_eff == '0)
        begin
            len_eff = LEFF_W'(1);
        end
        if (int'(len_eff) > MAX_NEEDLE)
        begin
            len_eff = LEFF_W'(MAX_NEEDLE);
        end
        len_m1 = len_eff - LEFF_W'(1);
    end

    // Compare the text byte against every needle byte
    always_comb
    begin
        for (int j = 0; j < MAX_NEEDLE; j++)
        begin
            cmp_vec[j] = (needle_reg[j] == item.data_byte);
        end
    end

    // Shift-and update of the partial-match vector
    generate
        if (MAX_NEEDLE > 1)
        begin : g_shift
            assign pmv_shift = {pmv_reg[MAX_NEEDLE-2:0], 1'b1};
        end
        else
        begin : g_single
            assign pmv_shift = 1'b1;
        end
    endgenerate

    assign hit        = pmv_next[len_m1[IDX_W-1:0]];
    assign len_m1_ext = POSITION_WIDTH'(len_m1);
    assign start_pos  = (pos_reg >= len_m1_ext) ? (pos_reg - len_m1_ext) : '0;
    assign start_wide = {{POS_OUT_W{1'b0}}, start_pos};

    // Work out the next search state and any result
    always_comb
    begin
        pmv_next      = pmv_reg;
        pos_next      = pos_reg;
        reported_next = reported_reg;
        res_valid     = 1'b0;
        res.found     = 1'b0;
        res.position  = '0;
        if (text_fire)
        begin
            if (!reported_reg)
            begin
                pmv_next = pmv_shift & cmp_vec;
                if (pmv_next[len_m1[IDX_W-1:0]])
                begin
                    res_valid     = 1'b1;
                    res.found     = 1'b1;
                    res.position  = start_wide[POS_OUT_W-1:0];
                    reported_next = 1'b1;
                end
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + POSITION_WIDTH'(1);
                end
            end
            if (item.last_of_text)
            begin
                if (!reported_next)
                begin
                    res_valid    = 1'b1;
                    res.found    = 1'b0;
                    res.position = '0;
                end
                pmv_next      = '0;
                pos_next      = '0;
                reported_next = 1'b0;
            end
        end
    end

    // Write needle bytes; indexes beyond the store are dropped
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_NEEDLE; j++)
        begin
            if (item_fire && (item.mode == MODE_NEEDLE) && (int'(item.needle_index) == j))
            begin
                needle_reg[j] <= item.data_byte;
            end
        end
    end

    // Hold search state and needle length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmv_reg      <= '0;
            pos_reg      <= '0;
            reported_reg <= 1'b0;
            len_reg      <= LEN_W'(1);
        end
        else
        begin
            pmv_reg      <= pmv_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
            if (cfg.valid && cfg.ready)
            begin
                len_reg <= cfg.needle_length;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_reg <= res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.found    = out_reg.found;
    assign result.position = out_reg.position;

`ifndef NO_ASSERTIONS
    // Skid entry is only used behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // End of text leaves a clean search state
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_fire && item.last_of_text) |=>
            (pmv_reg == '0 && pos_reg == '0 && !reported_reg))
        else $error("search state not cleared after end of text");

    // Text position advances by one on a searched byte that does not end text
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (text_fire && !item.last_of_text && !reported_reg && pos_reg != '1) |=>
            (pos_reg == $past(pos_reg) + POSITION_WIDTH'(1)))
        else $error("text position did not advance");

    // A result is only produced by a hit or by end of text
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (text_fire && (hit || item.last_of_text)))
        else $error("result without hit or end of text");
`endif

endmodule

### tb/sfm_search_checker.sv
module sfm_search_checker (
    input  logic  clk,
    input  logic  rst_n,
    sfm_item_if   item,
    sfm_result_if result,
    sfm_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding
);
    import sfm_pkg::*;

    // Shadow copy of the search engine
    logic [BYTE_W-1:0]             needle_copy [MAX_NEEDLE_DEF];
    logic [MAX_NEEDLE_DEF-1:0]     prefix_live;
    logic [POSITION_WIDTH_DEF-1:0] text_offset;
    logic                          match_seen;
    logic [LEN_W-1:0]              length_reg;

    // Search outcomes still owed by the block, oldest first
    result_t outcome_q[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_search();
        prefix_live = '0;
        text_offset = '0;
        match_seen  = 1'b0;
    endfunction

    // Advance the shadow engine by one item and queue the outcome it causes
    function automatic void predict_search(input logic m, input logic [NIDX_W-1:0] idx,
                                           input logic [BYTE_W-1:0] b, input logic lst);
        int                            span;
        logic [POSITION_WIDTH_DEF-1:0] start;
        result_t                       res;
        if (m == MODE_NEEDLE)
        begin
            needle_copy[idx] = b;
            return;
        end
        // Zero counts as one; anything past the store depth saturates
        if (length_reg == 0)
            span = 1;
        else if (length_reg > MAX_NEEDLE_DEF)
            span = MAX_NEEDLE_DEF;
        else
            span = int'(length_reg);
        if (!match_seen)
        begin
            for (int j = MAX_NEEDLE_DEF - 1; j > 0; j--)
                prefix_live[j] = prefix_live[j-1] && (needle_copy[j] == b);
            prefix_live[0] = (needle_copy[0] == b);
            if (prefix_live[span-1])
            begin
                if (int'(text_offset) >= span - 1)
                    start = text_offset - POSITION_WIDTH_DEF'(span - 1);
                else
                    start = '0;
                res.found    = 1'b1;
                res.position = start;
                outcome_q.push_back(res);
                match_seen = 1'b1;
            end
            // Hold the offset at its maximum once it gets there
            if (text_offset != '1)
                text_offset++;
        end
        if (lst)
        begin
            if (!match_seen)
            begin
                res.found    = 1'b0;
                res.position = '0;
                outcome_q.push_back(res);
            end
            clear_search();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_search();
            length_reg = 1;
            outcome_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Retire the result first; its item was accepted in an earlier cycle
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              result.found, result.position));
                else
                begin
                    want = outcome_q.pop_front();
                    if (result.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  result.found, want.found));
                    if (result.position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  result.position, want.position));
                end
            end
            if (cfg.valid && cfg.ready)
                length_reg = cfg.needle_length;
            if (item.valid && item.ready)
                predict_search(item.mode, item.needle_index, item.data_byte, item.last_of_text);
            outstanding = outcome_q.size();
        end
    end

endmodule

### tb/tb_substring_first_match_top.sv
module tb_substring_first_match_top;
    import sfm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int FILLER_BYTES = 7;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;
    int   send_idle;
    int   recv_idle;
    int   items_sent;
    int   span;

    // Stimulus-side copy of the needle, used to plant matches in the text
    logic [BYTE_W-1:0] pattern [MAX_NEEDLE_DEF];
    logic              narrow;
    logic [BYTE_W-1:0] sym_a;
    logic [BYTE_W-1:0] sym_b;

    sfm_item_if   item_bus ();
    sfm_result_if result_bus ();
    sfm_cfg_if    cfg_bus ();

    substring_first_match_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    sfm_search_checker search_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (result_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_idle);

    task automatic send_item(input logic m, input logic [NIDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] b, input logic lst);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.mode         <= m;
        item_bus.needle_index <= idx;
        item_bus.data_byte    <= b;
        item_bus.last_of_text <= lst;
        @(negedge clk);
        while (!item_bus.ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic write_needle(input int idx, input logic [BYTE_W-1:0] b);
        pattern[idx] = b;
        send_item(MODE_NEEDLE, NIDX_W'(idx), b, 1'($urandom_range(1)));
    endtask

    // Hold the item channel idle until every outcome is back
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        drain();
        if (v == 0)
            span = 1;
        else if (v > MAX_NEEDLE_DEF)
            span = MAX_NEEDLE_DEF;
        else
            span = int'(v);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.needle_length <= v;
        @(negedge clk);
        while (!cfg_bus.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        if (narrow)
            return $urandom_range(1) ? sym_a : sym_b;
        return BYTE_W'($urandom_range(255));
    endfunction

    // Send needle bytes from..upto as text, optionally closing the text
    task automatic send_run(input int from, input int upto, input logic close);
        for (int p = from; p <= upto; p++)
            send_item(MODE_TEXT, NIDX_W'(p), pattern[p], close && p == upto);
    endtask

    // One text of n bytes: random bytes, planted needle prefixes, stray needle writes
    task automatic send_text(input int n);
        int k;
        int p;
        int run;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(99) < 4)
                write_needle($urandom_range(MAX_NEEDLE_DEF - 1), pick_byte());
            else if ($urandom_range(99) < 25)
            begin
                run = $urandom_range(1) ? span : $urandom_range(1, span);
                for (p = 0; p < run && k < n; p++)
                begin
                    send_item(MODE_TEXT, NIDX_W'($urandom_range(31)), pattern[p], k == n - 1);
                    k++;
                end
            end
            else
            begin
                send_item(MODE_TEXT, NIDX_W'($urandom_range(31)), pick_byte(), k == n - 1);
                k++;
            end
        end
    endtask

    task automatic run_segment(input logic [LEN_W-1:0] len_val, input int budget);
        int stop;
        set_length(len_val);
        // A two-symbol alphabet makes partial and full matches common
        narrow = ($urandom_range(3) != 0);
        sym_a  = BYTE_W'($urandom_range(255));
        sym_b  = sym_a ^ (8'h01 << $urandom_range(7));
        for (int i = 0; i < span; i++)
            write_needle(i, pick_byte());
        stop = items_sent + budget;
        while (items_sent < stop)
            send_text(($urandom_range(4) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(1, 3 * span + 8));
    endtask

    initial
    begin
        int               target;
        int               seg;
        logic [LEN_W-1:0] len_val;
        rst_n                  = 1'b0;
        item_bus.valid        <= 1'b0;
        item_bus.mode         <= MODE_NEEDLE;
        item_bus.needle_index <= '0;
        item_bus.data_byte    <= '0;
        item_bus.last_of_text <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.needle_length <= '0;
        items_sent             = 0;
        span                   = 1;
        narrow                 = 1'b0;
        send_idle              = 19;
        recv_idle              = 75;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every needle entry before any text reads the store
        for (int i = 0; i < MAX_NEEDLE_DEF; i++)
            write_needle(i, (i == 0) ? 8'hA5 : (i == 30) ? 8'h00 : (i == 31) ? 8'hFF
                                                         : 8'($urandom_range(255)));

        // Single-byte needle: match mid-text, then ignored tail cleared silently
        send_item(MODE_TEXT, 0, 8'h00, 1'b0);
        send_item(MODE_TEXT, 0, 8'hA5, 1'b0);
        send_item(MODE_TEXT, 0, 8'hA5, 1'b0);
        send_item(MODE_TEXT, 0, 8'h7F, 1'b1);
        // Match on the last byte, then a text with no match
        send_item(MODE_TEXT, 31, 8'hA5, 1'b1);
        send_item(MODE_TEXT, 0, 8'h3C, 1'b0);
        send_item(MODE_TEXT, 0, 8'h5A, 1'b1);

        // Full-length needle matched by the whole text
        set_length(LEN_W'(MAX_NEEDLE_DEF));
        send_run(0, MAX_NEEDLE_DEF - 1, 1'b1);

        // Zero length behaves as one
        set_length(0);
        send_item(MODE_TEXT, 0, 8'hFF, 1'b0);
        send_item(MODE_TEXT, 0, 8'hA5, 1'b1);

        // Oversized length saturates; rewrite a needle byte in the middle of the text
        set_length('1);
        send_run(0, 15, 1'b0);
        write_needle(20, ~pattern[20]);
        send_run(16, MAX_NEEDLE_DEF - 1, 1'b1);

        // Random traffic in three idling phases
        target = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
            recv_idle = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
            target += RANDOM_ITEMS / 3;
            seg = 0;
            while (items_sent < target)
            begin
                if (seg == 0)
                    len_val = 1;
                else if (seg == 1)
                    len_val = LEN_W'(MAX_NEEDLE_DEF);
                else if ($urandom_range(9) == 0)
                    len_val = LEN_W'($urandom_range(63));
                else
                    len_val = LEN_W'($urandom_range(1, MAX_NEEDLE_DEF));
                run_segment(len_val, 120);
                seg++;
            end
        end

        // Five-byte needle matched at the end of a short filler text
        narrow = 1'b0;
        set_length(5);
        for (int i = 0; i < 5; i++)
            write_needle(i, 8'h11 + 8'(i));
        for (int i = 0; i < FILLER_BYTES; i++)
            send_item(MODE_TEXT, 0, 8'h00, 1'b0);
        send_run(0, 4, 1'b1);

        drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
src/sfm_pkg.sv
src/sfm_if.sv
src/substring_first_match_top.sv
tb/sfm_search_checker.sv
tb/tb_substring_first_match_top.sv
